FILE: sv/eulrot_pkg.sv
// ----------------------------------------------------------------------------
// eulrot_pkg
// Shared widths and the elaboration-time quarter-wave sine generator.
// ----------------------------------------------------------------------------
`default_nettype none

package eulrot_pkg;

  localparam int unsigned CoordW = 32;
  localparam int unsigned AngleW = 16;

  // pi/2 in Q2.30
  localparam logic [63:0] HalfPiQ30 = 64'd1686629713;

  // Taylor divisors (2n)(2n+1), n = 1..10
  localparam logic [63:0] TaylorDiv [1:10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
    64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };

  // Quarter-wave entry k of a table with 2**tbl_bits entries per turn,
  // magnitude in [0, 2**frac_bits]. Only evaluated at elaboration.
  function automatic logic [63:0] quarter_sine(input int unsigned k,
                                               input int unsigned frac_bits,
                                               input int unsigned tbl_bits);
    logic        [63:0] t;
    logic        [63:0] x2;
    logic        [63:0] term;
    logic signed [63:0] sum;
    int unsigned        n;
    t    = (64'(k) * HalfPiQ30 + (64'd1 << (tbl_bits - 3))) >> (tbl_bits - 2);
    x2   = (t * t) >> 30;
    term = t;
    sum  = signed'(t);
    for (n = 1; n <= 10; n++) begin
      term = ((term * x2) >> 30) / TaylorDiv[n];
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = '0;
    end
    if (sum > (64'sd1 <<< 30)) begin
      sum = 64'sd1 <<< 30;
    end
    return unsigned'((sum + (64'sd1 <<< (29 - frac_bits))) >>> (30 - frac_bits));
  endfunction

endpackage

`default_nettype wire

FILE: sv/eulrot_sincos.sv
// ----------------------------------------------------------------------------
// eulrot_sincos
// Sine and cosine of a binary angle from a quarter-wave constant table.
// ----------------------------------------------------------------------------
`default_nettype none

module eulrot_sincos #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic [eulrot_pkg::AngleW-1:0] angle_i,
  output logic signed [FRAC_BITS+1:0]        sin_o,
  output logic signed [FRAC_BITS+1:0]        cos_o
);
  import eulrot_pkg::*;

  localparam int unsigned QBits = SINE_TABLE_BITS - 2;
  localparam int unsigned Q     = 1 << QBits;

  logic [FRAC_BITS:0] qtab [0:Q];

  for (genvar k = 0; k <= Q; k++) begin : g_tab
    localparam logic [FRAC_BITS:0] Entry =
      (FRAC_BITS + 1)'(quarter_sine(k, FRAC_BITS, SINE_TABLE_BITS));
    assign qtab[k] = Entry;
  end

  logic [SINE_TABLE_BITS-1:0] idx;
  logic [1:0]                 quad_s;
  logic [1:0]                 quad_c;
  logic [QBits-1:0]           rem;
  logic [QBits:0]             k_s;
  logic [QBits:0]             k_c;
  logic [FRAC_BITS:0]         mag_s;
  logic [FRAC_BITS:0]         mag_c;

  assign idx    = angle_i[AngleW-1 -: SINE_TABLE_BITS];
  assign quad_s = idx[SINE_TABLE_BITS-1 -: 2];
  assign quad_c = quad_s + 2'd1;   // cos = sin a quarter turn ahead
  assign rem    = idx[QBits-1:0];

  // odd quadrants run the quarter wave backwards
  assign k_s = quad_s[0] ? ((QBits+1)'(Q) - {1'b0, rem}) : {1'b0, rem};
  assign k_c = quad_c[0] ? ((QBits+1)'(Q) - {1'b0, rem}) : {1'b0, rem};

  assign mag_s = qtab[k_s];
  assign mag_c = qtab[k_c];

  // lower half-turn is negative
  assign sin_o = quad_s[1] ? -signed'({1'b0, mag_s}) : signed'({1'b0, mag_s});
  assign cos_o = quad_c[1] ? -signed'({1'b0, mag_c}) : signed'({1'b0, mag_c});

endmodule

`default_nettype wire

FILE: sv/eulrot_plane.sv
// ----------------------------------------------------------------------------
// eulrot_plane
// Two-stage plane rotation: products, then round, saturate. Side data rides
// along with the item.
// ----------------------------------------------------------------------------
`default_nettype none

module eulrot_plane #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned PASS_W    = 32
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  valid_i,
  output logic                                       ready_o,
  input  wire logic signed [eulrot_pkg::CoordW-1:0]  a_i,
  input  wire logic signed [eulrot_pkg::CoordW-1:0]  b_i,
  input  wire logic signed [FRAC_BITS+1:0]           sin_i,
  input  wire logic signed [FRAC_BITS+1:0]           cos_i,
  input  wire logic        [PASS_W-1:0]              pass_i,
  output logic                                       valid_o,
  input  wire logic                                  ready_i,
  output logic signed [eulrot_pkg::CoordW-1:0]       a_o,
  output logic signed [eulrot_pkg::CoordW-1:0]       b_o,
  output logic        [PASS_W-1:0]                   pass_o
);
  import eulrot_pkg::*;

  localparam int unsigned PW = CoordW + FRAC_BITS + 2;  // exact product
  localparam int unsigned SW = PW + 1;                  // sum of two
  localparam logic signed [SW-1:0] Rnd = SW'(1) <<< (FRAC_BITS - 1);

  function automatic logic signed [CoordW-1:0] sat(input logic signed [SW-1:0] v);
    logic [SW-CoordW:0] top;
    top = v[SW-1:CoordW-1];
    if ((&top) || !(|top)) begin
      return v[CoordW-1:0];
    end else if (v[SW-1]) begin
      return {1'b1, {(CoordW-1){1'b0}}};
    end else begin
      return {1'b0, {(CoordW-1){1'b1}}};
    end
  endfunction

  // stage 1: products
  logic                 v1_q;
  logic signed [PW-1:0] ca_q, sb_q, sa_q, cb_q;
  logic [PASS_W-1:0]    pass1_q;
  // stage 2: rotated coordinates
  logic                    v2_q;
  logic signed [CoordW-1:0] na_q, nb_q;
  logic [PASS_W-1:0]       pass2_q;

  logic rdy1, rdy2;
  logic signed [PW-1:0] ca_d, sb_d, sa_d, cb_d;
  logic signed [SW-1:0] suma, sumb, sha, shb;

  assign rdy2    = !v2_q || ready_i;
  assign rdy1    = !v1_q || rdy2;
  assign ready_o = rdy1;

  assign ca_d = cos_i * a_i;
  assign sb_d = sin_i * b_i;
  assign sa_d = sin_i * a_i;
  assign cb_d = cos_i * b_i;

  assign suma = SW'(ca_q) - SW'(sb_q) + Rnd;
  assign sumb = SW'(sa_q) + SW'(cb_q) + Rnd;
  assign sha  = suma >>> FRAC_BITS;   // floor, half rounds up
  assign shb  = sumb >>> FRAC_BITS;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_q <= valid_i;
      end
      if (rdy2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy1 && valid_i) begin
      ca_q    <= ca_d;
      sb_q    <= sb_d;
      sa_q    <= sa_d;
      cb_q    <= cb_d;
      pass1_q <= pass_i;
    end
    if (rdy2 && v1_q) begin
      na_q    <= sat(sha);
      nb_q    <= sat(shb);
      pass2_q <= pass1_q;
    end
  end

  assign valid_o = v2_q;
  assign a_o     = na_q;
  assign b_o     = nb_q;
  assign pass_o  = pass2_q;

endmodule

`default_nettype wire

FILE: sv/euler_xyz_point_rotation.sv
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation
// Rotates a Q16.16 point about x, then y, then z by three binary angles.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one item is a point plus three angles. An item
//   is taken at a rising edge with s_axis_tvalid and s_axis_tready high.
//   Output stream (m_axis_*): one rotated, saturated point per input item,
//   in input order, held stable while m_axis_tready is low.
//   The pipeline is one register stage of table lookup, then two stages
//   per plane rotation (multiply, then round and saturate), three rotations
//   in a row.
//   Throughput: one item per cycle, set by the 7-stage pipeline with a
//   valid bit per stage; four 32 x (FRAC_BITS+2) multipliers per rotation.
//   Stalls: each stage takes a new item when it is empty or when the stage
//   after it moves, so bubbles close up while the output waits; input is
//   refused only when every stage holds an item.
//   Reset: rst_ni clears all valid bits; nothing is in flight afterwards.
//   Angles are truncated to the top SINE_TABLE_BITS bits before lookup.
// ----------------------------------------------------------------------------
`default_nettype none

module euler_xyz_point_rotation #(
  parameter int unsigned FRAC_BITS       = 16,
  parameter int unsigned SINE_TABLE_BITS = 10
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [31:0] x_in, [63:32] y_in, [95:64] z_in,
  // [111:96] angle_x, [127:112] angle_y, [143:128] angle_z
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [31:0] x_out, [63:32] y_out, [95:64] z_out
  output logic [95:0]       m_axis_tdata
);
  import eulrot_pkg::*;

  localparam int unsigned TW = FRAC_BITS + 2;   // signed sin/cos width

  // unpack input item
  logic signed [CoordW-1:0] x_in, y_in, z_in;
  logic        [AngleW-1:0] ang_x, ang_y, ang_z;

  assign x_in  = s_axis_tdata[31:0];
  assign y_in  = s_axis_tdata[63:32];
  assign z_in  = s_axis_tdata[95:64];
  assign ang_x = s_axis_tdata[111:96];
  assign ang_y = s_axis_tdata[127:112];
  assign ang_z = s_axis_tdata[143:128];

  // stage 0: sine/cosine lookup for all three angles
  logic signed [TW-1:0] sx_d, cx_d, sy_d, cy_d, sz_d, cz_d;

  eulrot_sincos #(.FRAC_BITS(FRAC_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_x (
    .angle_i(ang_x), .sin_o(sx_d), .cos_o(cx_d)
  );
  eulrot_sincos #(.FRAC_BITS(FRAC_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_y (
    .angle_i(ang_y), .sin_o(sy_d), .cos_o(cy_d)
  );
  eulrot_sincos #(.FRAC_BITS(FRAC_BITS), .SINE_TABLE_BITS(SINE_TABLE_BITS)) u_trig_z (
    .angle_i(ang_z), .sin_o(sz_d), .cos_o(cz_d)
  );

  logic                     v0_q;
  logic signed [CoordW-1:0] x0_q, y0_q, z0_q;
  logic signed [TW-1:0]     sx_q, cx_q, sy_q, cy_q, sz_q, cz_q;
  logic                     rdy0, rdy_p1;

  assign rdy0          = !v0_q || rdy_p1;
  assign s_axis_tready = rdy0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy0) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy0 && s_axis_tvalid) begin
      x0_q <= x_in;
      y0_q <= y_in;
      z0_q <= z_in;
      sx_q <= sx_d;
      cx_q <= cx_d;
      sy_q <= sy_d;
      cy_q <= cy_d;
      sz_q <= sz_d;
      cz_q <= cz_d;
    end
  end

  // rotation about x: (y, z); x and the later angles ride along
  localparam int unsigned P1W = CoordW + 4 * TW;
  logic                     v1, rdy_p2;
  logic signed [CoordW-1:0] y1, z1;
  logic [P1W-1:0]           pass1;

  eulrot_plane #(.FRAC_BITS(FRAC_BITS), .PASS_W(P1W)) u_rot_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v0_q),
    .ready_o (rdy_p1),
    .a_i     (y0_q),
    .b_i     (z0_q),
    .sin_i   (sx_q),
    .cos_i   (cx_q),
    .pass_i  ({x0_q, sy_q, cy_q, sz_q, cz_q}),
    .valid_o (v1),
    .ready_i (rdy_p2),
    .a_o     (y1),
    .b_o     (z1),
    .pass_o  (pass1)
  );

  logic signed [CoordW-1:0] x1;
  logic signed [TW-1:0]     sy1, cy1, sz1, cz1;
  assign {x1, sy1, cy1, sz1, cz1} = pass1;

  // rotation about y: (z, x); y and the z angle ride along
  localparam int unsigned P2W = CoordW + 2 * TW;
  logic                     v2, rdy_p3;
  logic signed [CoordW-1:0] z2, x2;
  logic [P2W-1:0]           pass2;

  eulrot_plane #(.FRAC_BITS(FRAC_BITS), .PASS_W(P2W)) u_rot_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v1),
    .ready_o (rdy_p2),
    .a_i     (z1),
    .b_i     (x1),
    .sin_i   (sy1),
    .cos_i   (cy1),
    .pass_i  ({y1, sz1, cz1}),
    .valid_o (v2),
    .ready_i (rdy_p3),
    .a_o     (z2),
    .b_o     (x2),
    .pass_o  (pass2)
  );

  logic signed [CoordW-1:0] y2;
  logic signed [TW-1:0]     sz2, cz2;
  assign {y2, sz2, cz2} = pass2;

  // rotation about z: (x, y); its last stage is the output register
  logic signed [CoordW-1:0] x3, y3, z3;

  eulrot_plane #(.FRAC_BITS(FRAC_BITS), .PASS_W(CoordW)) u_rot_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2),
    .ready_o (rdy_p3),
    .a_i     (x2),
    .b_i     (y2),
    .sin_i   (sz2),
    .cos_i   (cz2),
    .pass_i  (z2),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .a_o     (x3),
    .b_o     (y3),
    .pass_o  (z3)
  );

  assign m_axis_tdata = {z3, y3, x3};

endmodule

`default_nettype wire

FILE: sim/euler_xyz_point_rotation_tb.sv
// ----------------------------------------------------------------------------
// euler_xyz_point_rotation_tb
// Streams points and angles through the XYZ rotator and checks every result
// against a bit-exact predictor kept in a small scoreboard. A directed set
// covers the coordinate extremes, quadrant angles, truncated angle bits and
// saturation. A long random run follows, with idle bursts on both sides.
// ----------------------------------------------------------------------------
module euler_xyz_point_rotation_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import eulrot_pkg::*;

  localparam int unsigned FracBits  = 16;
  localparam int unsigned TblBits   = 10;
  localparam int unsigned NumRandom = 1830;
  localparam int unsigned QuietTail = 200;
  localparam int unsigned DrainMax  = 2000;
  localparam int unsigned Latency   = 7;

  // pi/2 in Q2.30, basis of the sine table
  localparam longint unsigned HalfPi = 64'd1686629713;

  localparam logic signed [CoordW-1:0] CoordMax = 32'sh7fff_ffff;
  localparam logic signed [CoordW-1:0] CoordMin = 32'sh8000_0000;

  // One input item, x in the lowest bits (matches s_axis_tdata)
  typedef struct packed {
    logic [AngleW-1:0]        angle_z;
    logic [AngleW-1:0]        angle_y;
    logic [AngleW-1:0]        angle_x;
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } point_item_t;

  // One result item (matches m_axis_tdata)
  typedef struct packed {
    logic signed [CoordW-1:0] z;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } rotated_t;

  // --------------------------------------------------------------------------
  // Scoreboard: predicts the rotated point for each accepted item and checks
  // results in order.
  // --------------------------------------------------------------------------
  class rotation_scoreboard;
    rotated_t rotated_q[$];
    int       errors  = 0;

    // Quarter-wave entry k: Taylor series in Q2.30, rounded to FracBits
    function longint quarter_wave(longint unsigned k);
      longint unsigned qn;
      longint unsigned t;
      longint unsigned x2;
      longint unsigned term;
      longint          acc;
      qn   = 64'd1 << (TblBits - 2);
      t    = (k * HalfPi + qn / 2) / qn;
      x2   = (t * t) >> 30;
      term = t;
      acc  = longint'(t);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / longint'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) acc = acc - longint'(term);
        else            acc = acc + longint'(term);
      end
      if (acc < 0) acc = 0;
      if (acc > (64'sd1 <<< 30)) acc = 64'sd1 <<< 30;
      return (acc + (64'sd1 <<< (29 - FracBits))) >>> (30 - FracBits);
    endfunction

    // Full-turn lookup by quadrant mirroring
    function longint sine_at(longint unsigned idx);
      longint unsigned qn;
      longint unsigned quad;
      longint unsigned r;
      longint          v;
      qn   = 64'd1 << (TblBits - 2);
      quad = (idx >> (TblBits - 2)) & 64'd3;
      r    = idx & (qn - 1);
      v    = quad[0] ? quarter_wave(qn - r) : quarter_wave(r);
      return quad[1] ? -v : v;
    endfunction

    // Round half up, then clamp to signed 32 bits
    function longint round_clamp(longint v);
      longint w;
      longint f;
      w = v + (64'sd1 <<< (FracBits - 1));
      f = w >>> FracBits;
      if (f > 64'sd2147483647)  f = 64'sd2147483647;
      if (f < -64'sd2147483648) f = -64'sd2147483648;
      return f;
    endfunction

    // (a, b) -> (c*a - s*b, s*a + c*b), both from the old pair
    function void turn_plane(inout longint a, inout longint b, input logic [AngleW-1:0] ang);
      longint unsigned idx;
      longint          s;
      longint          c;
      longint          na;
      longint          nb;
      idx = longint'(ang) >> (AngleW - TblBits);
      s   = sine_at(idx);
      c   = sine_at((idx + (64'd1 << (TblBits - 2))) & ((64'd1 << TblBits) - 1));
      na  = round_clamp(c * a - s * b);
      nb  = round_clamp(s * a + c * b);
      a   = na;
      b   = nb;
    endfunction

    function rotated_t rotate_xyz(point_item_t p);
      longint   px;
      longint   py;
      longint   pz;
      rotated_t r;
      px = p.x;
      py = p.y;
      pz = p.z;
      turn_plane(py, pz, p.angle_x);
      turn_plane(pz, px, p.angle_y);
      turn_plane(px, py, p.angle_z);
      r.x = px[CoordW-1:0];
      r.y = py[CoordW-1:0];
      r.z = pz[CoordW-1:0];
      return r;
    endfunction

    function void note_point(point_item_t p);
      rotated_q.push_back(rotate_xyz(p));
    endfunction

    function void report_field(string name, logic signed [CoordW-1:0] want,
                               logic signed [CoordW-1:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t ns: %s mismatch, expected %0d (%h), actual %0d (%h)",
                 $time, name, want, want, got, got);
      end
    endfunction

    function void check_rotated(rotated_t got);
      rotated_t want;
      if (rotated_q.size() == 0) begin
        errors++;
        $display("%0t ns: unexpected result, expected none, actual %h", $time, got);
        return;
      end
      want = rotated_q.pop_front();
      report_field("x_out", want.x, got.x);
      report_field("y_out", want.y, got.y);
      report_field("z_out", want.z, got.z);
    endfunction

    function int pending();
      return rotated_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic         clk_i = 1'b0;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata;   // x_in, y_in, z_in, angle_x, angle_y, angle_z
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [95:0]  m_axis_tdata;   // x_out, y_out, z_out

  rotation_scoreboard sb;
  bit                 quiet = 1'b0;  // no idling on either side near the end
  int                 send_gap_pct = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  euler_xyz_point_rotation #(
    .FRAC_BITS      (FracBits),
    .SINE_TABLE_BITS(TblBits)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Output monitor: pre-edge values are read in the active region
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_rotated(m_axis_tdata);
  end

  // Receiver backpressure: stall bursts at a rate of 0, 5 or 20 percent, redrawn when phase_cnt wraps
  initial begin
    int stall_left;
    int stall_pct;
    int phase_cnt;
    stall_left = 0;
    stall_pct  = 0;
    phase_cnt  = 0;
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (phase_cnt == 0) begin
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 5;
          default: stall_pct = 20;
        endcase
      end
      phase_cnt = (phase_cnt + 1) % 64;
      if (quiet) begin
        stall_left    = 0;
        m_axis_tready = 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left    = $urandom_range(1, 16) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. Called at a falling edge, return at a falling edge.
  // --------------------------------------------------------------------------
  function automatic point_item_t make_point(logic signed [CoordW-1:0] x,
                                             logic signed [CoordW-1:0] y,
                                             logic signed [CoordW-1:0] z,
                                             logic [AngleW-1:0] ax,
                                             logic [AngleW-1:0] ay,
                                             logic [AngleW-1:0] az);
    point_item_t p;
    p.x = x;  p.y = y;  p.z = z;
    p.angle_x = ax;  p.angle_y = ay;  p.angle_z = az;
    return p;
  endfunction

  task automatic send_point(input point_item_t p);
    int gap;
    if (!quiet && $urandom_range(0, 99) < send_gap_pct) begin
      gap = $urandom_range(1, 16);
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  = p;
    s_axis_tvalid = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_point(p);
    @(negedge clk_i);
  endtask

  // Coordinate: full range, small magnitude, or an edge value
  function automatic logic signed [CoordW-1:0] pick_coord();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5, 6:    return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      7: begin
        case ($urandom_range(0, 4))
          0:       return CoordMax;
          1:       return CoordMin;
          2:       return 32'sd0;
          3:       return 32'sd1;
          default: return -32'sd1;
        endcase
      end
      default:    return $signed($urandom_range(0, 32'h0000_4000)) - 32'sh0000_2000;
    endcase
  endfunction

  // Angle: full range, or near a quadrant boundary
  function automatic logic [AngleW-1:0] pick_angle();
    logic [AngleW-1:0] a;
    if ($urandom_range(0, 3) != 0) begin
      a = $urandom_range(0, 16'hffff);
    end else begin
      a = 16'($urandom_range(0, 3) * 16'h4000);
      a = a + 16'($urandom_range(0, 128)) - 16'd64;
    end
    return a;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    int wait_cnt;
    int total_errors;
    sb = new();
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: zero, extremes, quadrants, truncated angle bits, saturation
    send_point(make_point(32'sd0, 32'sd0, 32'sd0, 16'h0000, 16'h0000, 16'h0000));
    send_point(make_point(CoordMax, CoordMin, CoordMax, 16'h0000, 16'h0000, 16'h0000));
    send_point(make_point(CoordMin, CoordMax, CoordMin, 16'h0000, 16'h0000, 16'h0000));
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          16'h4000, 16'h0000, 16'h0000));
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          16'h0000, 16'h8000, 16'h0000));
    send_point(make_point(32'sh0001_0000, 32'sh0002_0000, 32'sh0003_0000,
                          16'h0000, 16'h0000, 16'hc000));
    send_point(make_point(32'sh0001_0000, -32'sh0002_0000, 32'sh0003_0000,
                          16'h4000, 16'h8000, 16'hc000));
    // Angle bits below the table resolution are dropped
    send_point(make_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                          16'h003f, 16'h003f, 16'h003f));
    send_point(make_point(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000,
                          16'hffff, 16'hffff, 16'hffff));
    // 45 degrees on full-scale coordinates saturates in the x and y rotations
    send_point(make_point(CoordMax, CoordMax, CoordMax, 16'h2000, 16'h2000, 16'h2000));
    send_point(make_point(CoordMin, CoordMin, CoordMin, 16'h2000, 16'h2000, 16'h2000));
    send_point(make_point(CoordMax, CoordMin, CoordMax, 16'h6000, 16'ha000, 16'he000));
    send_point(make_point(CoordMin, CoordMax, CoordMin, 16'h4000, 16'h4000, 16'h4000));
    // Rounding of tiny values, both signs
    send_point(make_point(32'sd1, 32'sd1, 32'sd1, 16'h2000, 16'h2000, 16'h2000));
    send_point(make_point(-32'sd1, -32'sd1, -32'sd1, 16'h2000, 16'h2000, 16'h2000));
    send_point(make_point(32'sd1, -32'sd1, 32'sd1, 16'h1555, 16'h2aaa, 16'h7fff));
    send_point(make_point(32'sh7fff_0000, -32'sh0000_8000, 32'sh0000_8000,
                          16'h8000, 16'h8000, 16'h8000));
    send_point(make_point(32'sh1234_5678, 32'sh8765_4321, 32'sh0f0f_f0f0,
                          16'h1234, 16'h5678, 16'h9abc));
    send_point(make_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh5555_5555,
                          16'h5555, 16'haaaa, 16'h5555));
    send_point(make_point(32'shffff_0000, 32'sh0000_ffff, 32'sh8000_0001,
                          16'h3fff, 16'h7fff, 16'hbfff));

    // Random part
    for (int i = 0; i < NumRandom; i++) begin
      if (i % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       send_gap_pct = 0;
          1:       send_gap_pct = 10;
          default: send_gap_pct = 40;
        endcase
      end
      if (i >= NumRandom - QuietTail) quiet = 1'b1;
      // Let the pipeline run dry once, then refill
      if (i == NumRandom / 3) begin
        s_axis_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge clk_i);
      end
      send_point(make_point(pick_coord(), pick_coord(), pick_coord(),
                            pick_angle(), pick_angle(), pick_angle()));
    end
    s_axis_tvalid = 1'b0;

    // Drain, bounded
    wait_cnt = 0;
    while (sb.pending() != 0 && wait_cnt < DrainMax) begin
      @(negedge clk_i);
      wait_cnt++;
    end
    repeat (Latency * 3) @(negedge clk_i);

    total_errors = sb.errors;
    if (sb.pending() != 0) begin
      $display("%0t ns: %0d results missing, expected 0 pending, actual %0d",
               $time, sb.pending(), sb.pending());
      total_errors += sb.pending();
    end
    if (total_errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("%0t ns: timeout", $time);
    $display("DONE: errors detected");
    $finish;
  end

endmodule

FILE: filelist.f
sv/eulrot_pkg.sv
sv/eulrot_sincos.sv
sv/eulrot_plane.sv
sv/euler_xyz_point_rotation.sv
sim/euler_xyz_point_rotation_tb.sv
